@@ hdl/fpdf_pkg.sv @@
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared types, character codes and scale constants of the fixed-point
// decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_FRAC  = 1'b1;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_DOT   = 7'h2E;

	typedef struct packed {
		logic             neg;
		logic [1:0]       fd;
		logic [15:0]      whole;
		logic [9:0]       rem;
		logic [3:0][3:0]  wdig;
		logic [3:0][3:0]  rdig;
	} work_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SIGN,
		PH_WHOLE,
		PH_POINT,
		PH_FRAC
	} phase_t;

	// reciprocal of 10^e scaled by 2^shift, exact for magnitudes up to 32768
	function automatic logic [16:0] scale_recip(input logic [1:0] e);
		logic [16:0] r;
		unique case (e)
			2'd0: r = 17'd65536;
			2'd1: r = 17'd52429;
			2'd2: r = 17'd41944;
			default: r = 17'd33555;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] scale_shift(input logic [1:0] e);
		logic [4:0] s;
		unique case (e)
			2'd0: s = 5'd16;
			2'd1: s = 5'd19;
			2'd2: s = 5'd22;
			default: s = 5'd25;
		endcase
		return s;
	endfunction

	function automatic logic [9:0] scale_factor(input logic [1:0] e);
		logic [9:0] f;
		unique case (e)
			2'd0: f = 10'd1;
			2'd1: f = 10'd10;
			2'd2: f = 10'd100;
			default: f = 10'd1000;
		endcase
		return f;
	endfunction

endpackage

@@ hdl/fpdf_split.sv @@
// ----------------------------------------------------------------------------
// fpdf_split
// Four pipeline stages: sign and magnitude, integer part by reciprocal
// multiply, remainder, and shortening of an over-long remainder.
// ----------------------------------------------------------------------------
module fpdf_split (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 in_ready,
	input  logic [15:0]          value,
	input  logic [1:0]           scale,
	input  logic [1:0]           frac,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fpdf_pkg::work_t      out_work
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy1, rdy2, rdy3, rdy4;

	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [1:0]  exp_s1, exp_s2;
	logic [1:0]  fd_s1, fd_s2, fd_s3, fd_s4;
	logic [15:0] mag_s1, mag_s2;
	logic [15:0] whole_s2, whole_s3, whole_s4;
	logic [9:0]  rem_s3, rem_s4;

	logic [32:0] prod;
	logic [32:0] shifted;
	logic [25:0] back;
	logic [15:0] rem_full;
	logic [17:0] rem_prod;
	logic [9:0]  rem_div;
	logic        shorten;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign prod     = {17'b0, mag_s1} * {16'b0, fpdf_pkg::scale_recip(exp_s1)};
	assign shifted  = prod >> fpdf_pkg::scale_shift(exp_s1);
	assign back     = {10'b0, whole_s2} * {16'b0, fpdf_pkg::scale_factor(exp_s2)};
	assign rem_full = mag_s2 - back[15:0];
	assign rem_prod = {8'b0, rem_s3} * 18'd205;
	assign rem_div  = {3'b0, rem_prod[17:11]};
	assign shorten  = (fd_s3 == 2'd1 && rem_s3 > 10'd9) ||
		(fd_s3 == 2'd2 && rem_s3 > 10'd99);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= start;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && start) begin
			neg_s1 <= value[15];
			mag_s1 <= value[15] ? (16'd0 - value) : value;
			exp_s1 <= scale;
			fd_s1  <= frac;
		end
		if (rdy2 && v_s1) begin
			neg_s2   <= neg_s1;
			mag_s2   <= mag_s1;
			exp_s2   <= exp_s1;
			fd_s2    <= fd_s1;
			whole_s2 <= shifted[15:0];
		end
		if (rdy3 && v_s2) begin
			neg_s3   <= neg_s2;
			fd_s3    <= fd_s2;
			whole_s3 <= whole_s2;
			rem_s3   <= rem_full[9:0];
		end
		if (rdy4 && v_s3) begin
			neg_s4   <= neg_s3;
			fd_s4    <= fd_s3;
			whole_s4 <= whole_s3;
			rem_s4   <= shorten ? rem_div : rem_s3;
		end
	end

	assign out_valid      = v_s4;
	assign out_work.neg   = neg_s4;
	assign out_work.fd    = fd_s4;
	assign out_work.whole = whole_s4;
	assign out_work.rem   = rem_s4;
	assign out_work.wdig  = '0;
	assign out_work.rdig  = '0;

endmodule

@@ hdl/fpdf_digit.sv @@
// ----------------------------------------------------------------------------
// fpdf_digit
// One pipeline stage that peels the lowest decimal digit off both the
// integer part and the remainder.
// ----------------------------------------------------------------------------
module fpdf_digit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fpdf_pkg::work_t      in_work,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fpdf_pkg::work_t      out_work
);

	logic            valid_q;
	fpdf_pkg::work_t work_q;

	logic [32:0] wprod;
	logic [15:0] wq;
	logic [15:0] wq10;
	logic [15:0] wd;
	logic [17:0] rprod;
	logic [9:0]  rq;
	logic [9:0]  rq10;
	logic [9:0]  rd;

	assign in_ready = !valid_q || out_ready;

	assign wprod = {17'b0, in_work.whole} * 33'd52429;
	assign wq    = {2'b0, wprod[32:19]};
	assign wq10  = {wq[12:0], 3'b0} + {wq[14:0], 1'b0};
	assign wd    = in_work.whole - wq10;
	assign rprod = {8'b0, in_work.rem} * 18'd205;
	assign rq    = {3'b0, rprod[17:11]};
	assign rq10  = {rq[6:0], 3'b0} + {rq[8:0], 1'b0};
	assign rd    = in_work.rem - rq10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_q.neg   <= in_work.neg;
			work_q.fd    <= in_work.fd;
			work_q.whole <= wq;
			work_q.rem   <= rq;
			work_q.wdig  <= {wd[3:0], in_work.wdig[3:1]};
			work_q.rdig  <= {rd[3:0], in_work.rdig[3:1]};
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

@@ hdl/fpdf_emit.sv @@
// ----------------------------------------------------------------------------
// fpdf_emit
// Character sequencer: sign, integer digits, point and fraction digits,
// one character per cycle, with the final one flagged.
// ----------------------------------------------------------------------------
module fpdf_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fpdf_pkg::work_t      in_work,
	output logic                 char_strobe,
	output logic [6:0]           character,
	output logic                 last_char
);

	fpdf_pkg::phase_t phase_q, phase_d;
	logic [2:0]       idx_q, idx_d;
	logic [4:0][3:0]  wdig_q;
	logic [2:0][3:0]  rdig_q;
	logic [1:0]       nrm1_q;
	logic             has_frac_q;

	logic [4:0][3:0]  w_all;
	logic [2:0]       nwm1;
	logic [1:0]       rsig;
	logic [1:0]       nrm1;
	logic             load;
	logic             last;

	assign w_all = {in_work.whole[3:0], in_work.wdig};

	always_comb begin
		priority if (w_all[4] != 4'd0) nwm1 = 3'd4;
		else if (w_all[3] != 4'd0)     nwm1 = 3'd3;
		else if (w_all[2] != 4'd0)     nwm1 = 3'd2;
		else if (w_all[1] != 4'd0)     nwm1 = 3'd1;
		else                           nwm1 = 3'd0;
	end

	always_comb begin
		priority if (in_work.rdig[2] != 4'd0) rsig = 2'd2;
		else if (in_work.rdig[1] != 4'd0)     rsig = 2'd1;
		else                                  rsig = 2'd0;
	end

	assign nrm1 = (rsig > (in_work.fd - 2'd1)) ? rsig : (in_work.fd - 2'd1);

	assign last = (phase_q == fpdf_pkg::PH_WHOLE && idx_q == 3'd0 && !has_frac_q) ||
		(phase_q == fpdf_pkg::PH_FRAC && idx_q == 3'd0);
	assign in_ready = (phase_q == fpdf_pkg::PH_IDLE) || last;
	assign load     = in_valid && in_ready;

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		unique case (phase_q)
			fpdf_pkg::PH_IDLE: begin
			end
			fpdf_pkg::PH_SIGN: begin
				phase_d = fpdf_pkg::PH_WHOLE;
			end
			fpdf_pkg::PH_WHOLE: begin
				if (idx_q == 3'd0) begin
					phase_d = has_frac_q ? fpdf_pkg::PH_POINT : fpdf_pkg::PH_IDLE;
				end else begin
					idx_d = idx_q - 3'd1;
				end
			end
			fpdf_pkg::PH_POINT: begin
				phase_d = fpdf_pkg::PH_FRAC;
				idx_d   = {1'b0, nrm1_q};
			end
			fpdf_pkg::PH_FRAC: begin
				if (idx_q == 3'd0) begin
					phase_d = fpdf_pkg::PH_IDLE;
				end else begin
					idx_d = idx_q - 3'd1;
				end
			end
			default: begin
				phase_d = fpdf_pkg::PH_IDLE;
			end
		endcase
		if (load) begin
			phase_d = in_work.neg ? fpdf_pkg::PH_SIGN : fpdf_pkg::PH_WHOLE;
			idx_d   = nwm1;
		end
	end

	// outputs
	always_comb begin
		char_strobe = 1'b1;
		character   = fpdf_pkg::CH_ZERO;
		unique case (phase_q)
			fpdf_pkg::PH_IDLE:  char_strobe = 1'b0;
			fpdf_pkg::PH_SIGN:  character = fpdf_pkg::CH_MINUS;
			fpdf_pkg::PH_WHOLE: character = fpdf_pkg::CH_ZERO + {3'b0, wdig_q[idx_q]};
			fpdf_pkg::PH_POINT: character = fpdf_pkg::CH_DOT;
			fpdf_pkg::PH_FRAC:  character = fpdf_pkg::CH_ZERO + {3'b0, rdig_q[idx_q[1:0]]};
			default:            char_strobe = 1'b0;
		endcase
		last_char = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fpdf_pkg::PH_IDLE;
			idx_q   <= 3'd0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wdig_q     <= w_all;
			rdig_q     <= in_work.rdig[2:0];
			nrm1_q     <= nrm1;
			has_frac_q <= (in_work.fd != 2'd0);
		end
	end

endmodule

@@ hdl/fixed_point_decimal_formatter_top.sv @@
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_top
// Signed 16-bit fixed-point value to ASCII decimal text, one character
// per cycle.
//
// Channel   Signals                               Transfer
// command   start, busy, value                    start && !busy
// result    char_strobe, character, last_char     char_strobe, no wait
// config    cfg_wr_en, cfg_index, cfg_wdata       cfg_wr_en, no wait
//
// Eight pipeline stages (four split stages, four digit stages) feed the
// character sequencer, which registers a value's first character when it
// takes the value. A value of n characters (1 to 10) holds the sequencer
// until its last character, and the pipeline keeps taking commands meanwhile.
// Results cannot be held off; busy rises when the sequencer backs
// up the pipeline. Reset clears all valid bits and both configuration registers.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_wdata,
	output logic        char_strobe,
	output logic [6:0]  character,
	output logic        last_char
);

	logic [1:0] scale_q;
	logic [1:0] frac_q;
	logic       split_ready;

	logic            valid [0:4];
	logic            ready [0:4];
	fpdf_pkg::work_t work  [0:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 2'd0;
			frac_q  <= 2'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fpdf_pkg::REG_SCALE: scale_q <= cfg_wdata;
				fpdf_pkg::REG_FRAC:  frac_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign busy = !split_ready;

	fpdf_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.in_ready  (split_ready),
		.value     (value),
		.scale     (scale_q),
		.frac      (frac_q),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_work  (work[0])
	);

	for (genvar g = 0; g < 4; g++) begin : g_digit
		fpdf_digit u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[g]),
			.in_ready  (ready[g]),
			.in_work   (work[g]),
			.out_valid (valid[g+1]),
			.out_ready (ready[g+1]),
			.out_work  (work[g+1])
		);
	end

	fpdf_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid[4]),
		.in_ready    (ready[4]),
		.in_work     (work[4]),
		.char_strobe (char_strobe),
		.character   (character),
		.last_char   (last_char)
	);

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> char_strobe)
		else $error("last_char without char_strobe");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && !last_char |=> char_strobe)
		else $error("gap inside one value's text");

	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && character == fpdf_pkg::CH_MINUS |=>
		char_strobe && character != fpdf_pkg::CH_MINUS && character != fpdf_pkg::CH_DOT)
		else $error("sign not followed by a digit");

	a_point_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && character == fpdf_pkg::CH_DOT |->
		!last_char ##1 (char_strobe && character != fpdf_pkg::CH_DOT))
		else $error("point not followed by a fraction digit");

endmodule
